[hdl/chit_pkg.sv]
// chit_pkg: shared types and codes for the chained hash id table
// request/response structs, action and status codes, sequencer states
// depends on nothing; used by chained_hash_id_table, chit_checker and tb
package chit_pkg;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_FIND   = 2'd2,
        ACT_UNIQUE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // id that a find never matches
    localparam logic [31:0] KEY_NONE = 32'hFFFF_FFFF;

    typedef struct packed {
        action_t            action;
        logic signed [31:0] key_id;
        logic [31:0]        handle;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [31:0]        found_handle;
        logic signed [31:0] unique_id;
    } rsp_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL_LO,
        S_MUL_HI,
        S_REM,
        S_HEAD_RD,
        S_HEAD_WAIT,
        S_WALK_RD,
        S_WALK_CHK,
        S_SCAN_HEAD_RD,
        S_SCAN_HEAD_WAIT,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FINISH
    } state_t;

endpackage

[hdl/chained_hash_id_table.sv]
// an insert reads the chain head and links a popped slot in; find, remove and ensure-unique walk
// one chain, and a clash in ensure-unique then scans every bucket and stored entry; an insert into
// a full pool or a find of minus one goes straight to the result; a stalled output holds the result
// the bucket comes from a reciprocal multiply by each 16-bit half of the id, then one
// multiply-subtract; every chain step is one registered read of the entry memories
// throughput: one transaction at a time; in_ready is low while one is in flight
// reset: after rst_n, a clearing pass fills memories
module chained_hash_id_table #(
    parameter int BUCKETS  = 101,
    parameter int CAPACITY = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  chit_pkg::req_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output chit_pkg::rsp_t  out_data
);

    localparam int BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int SW   = $clog2(CAPACITY);
    localparam int LW   = $clog2(CAPACITY + 1);
    localparam int MAXN = (BUCKETS > CAPACITY) ? BUCKETS : CAPACITY;
    localparam int CW   = $clog2(MAXN);
    localparam logic [LW-1:0] NULL_LINK = LW'(CAPACITY);
    // reciprocal of BUCKETS scaled by 2^(32+QL), rounded up so the quotient is exact
    localparam int QL = $clog2(BUCKETS);
    localparam logic [33:0] RECIP = 34'(((66'd1 << (32 + QL)) / 66'(BUCKETS)) + 66'd1);

    // memories
    logic [LW-1:0] head_mem  [BUCKETS];
    logic [LW-1:0] link_mem  [CAPACITY];
    logic [31:0]   key_mem   [CAPACITY];
    logic [31:0]   hnd_mem   [CAPACITY];
    logic [SW-1:0] stack_mem [CAPACITY];

    logic [LW-1:0] head_q, link_q;
    logic [31:0]   key_q, hnd_q;
    logic [SW-1:0] stack_q;

    // memory port controls
    logic          head_we;
    logic [BW-1:0] head_waddr, head_raddr;
    logic [LW-1:0] head_wdata;
    logic          link_we;
    logic [SW-1:0] link_waddr;
    logic [LW-1:0] link_wdata;
    logic          ent_we;
    logic [SW-1:0] ent_waddr, ent_raddr;
    logic          stack_we;
    logic [SW-1:0] stack_waddr, stack_wdata, stack_raddr;

    // sequencer registers
    chit_pkg::state_t   state_reg, state_next;
    chit_pkg::action_t  act_reg, act_next;
    logic [31:0]        key_reg, key_next;
    logic [31:0]        hnd_reg, hnd_next;
    logic [65:0]        prod_reg, prod_next;
    logic [BW-1:0]      rem_reg, rem_next;
    logic [LW-1:0]      cur_reg, cur_next;
    logic [LW-1:0]      prev_reg, prev_next;
    logic signed [31:0] best_reg, best_next;
    logic [BW-1:0]      scan_b_reg, scan_b_next;
    logic [LW-1:0]      free_cnt_reg, free_cnt_next;
    logic [CW-1:0]      clr_cnt_reg, clr_cnt_next;
    chit_pkg::status_t  status_reg, status_next;
    logic [31:0]        found_reg, found_next;
    logic [31:0]        uid_reg, uid_next;
    logic               out_valid_reg, out_valid_next;
    chit_pkg::rsp_t     out_data_reg, out_data_next;

    // shared multiplier: one 16-bit half of the id times the reciprocal
    logic [15:0] mul_in;
    logic [49:0] mul_part;
    logic [31:0] quo;
    logic [31:0] rem_full;
    assign mul_in   = (state_reg == chit_pkg::S_MUL_HI) ? key_reg[31:16] : key_reg[15:0];
    assign mul_part = {34'd0, mul_in} * {16'd0, RECIP};

    // quotient from the product, remainder by multiply-subtract
    assign quo      = 32'(prod_reg >> (32 + QL));
    assign rem_full = key_reg - quo * 32'(BUCKETS);

    // memory writes and registered reads
    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_waddr] <= head_wdata;
        end
        head_q <= head_mem[head_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_q <= link_mem[ent_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            key_mem[ent_waddr] <= key_reg;
            hnd_mem[ent_waddr] <= hnd_reg;
        end
        key_q <= key_mem[ent_raddr];
        hnd_q <= hnd_mem[ent_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        stack_q <= stack_mem[stack_raddr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= chit_pkg::S_CLEAR;
            free_cnt_reg  <= NULL_LINK;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_cnt_reg  <= free_cnt_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        key_reg      <= key_next;
        hnd_reg      <= hnd_next;
        prod_reg     <= prod_next;
        rem_reg      <= rem_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        best_reg     <= best_next;
        scan_b_reg   <= scan_b_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
        uid_reg      <= uid_next;
        out_data_reg <= out_data_next;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        key_next       = key_reg;
        hnd_next       = hnd_reg;
        prod_next      = prod_reg;
        rem_next       = rem_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        best_next      = best_reg;
        scan_b_next    = scan_b_reg;
        free_cnt_next  = free_cnt_reg;
        clr_cnt_next   = clr_cnt_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        uid_next       = uid_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;

        head_we     = 1'b0;
        head_waddr  = rem_reg;
        head_wdata  = link_q;
        head_raddr  = rem_reg;
        link_we     = 1'b0;
        link_waddr  = prev_reg[SW-1:0];
        link_wdata  = link_q;
        ent_we      = 1'b0;
        ent_waddr   = stack_q;
        ent_raddr   = cur_reg[SW-1:0];
        stack_we    = 1'b0;
        stack_waddr = free_cnt_reg[SW-1:0];
        stack_wdata = cur_reg[SW-1:0];
        stack_raddr = SW'(free_cnt_reg - LW'(1));

        case (state_reg)
            // fill chain heads with null and the free stack with every slot
            chit_pkg::S_CLEAR:
            begin
                if ({1'b0, clr_cnt_reg} < (CW + 1)'(BUCKETS))
                begin
                    head_we    = 1'b1;
                    head_waddr = clr_cnt_reg[BW-1:0];
                    head_wdata = NULL_LINK;
                end
                if ({1'b0, clr_cnt_reg} < (CW + 1)'(CAPACITY))
                begin
                    stack_we    = 1'b1;
                    stack_waddr = clr_cnt_reg[SW-1:0];
                    stack_wdata = clr_cnt_reg[SW-1:0];
                end
                clr_cnt_next = clr_cnt_reg + CW'(1);
                if (clr_cnt_reg == CW'(MAXN - 1))
                begin
                    state_next = chit_pkg::S_IDLE;
                end
            end

            chit_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next     = in_data.action;
                    key_next     = in_data.key_id;
                    hnd_next     = in_data.handle;
                    status_next  = chit_pkg::ST_OK;
                    found_next   = '0;
                    uid_next     = '0;
                    state_next   = chit_pkg::S_MUL_LO;
                    if (in_data.action == chit_pkg::ACT_INSERT && free_cnt_reg == '0)
                    begin
                        status_next = chit_pkg::ST_FULL;
                        state_next  = chit_pkg::S_FINISH;
                    end
                    else if (in_data.action == chit_pkg::ACT_FIND &&
                             in_data.key_id == chit_pkg::KEY_NONE)
                    begin
                        status_next = chit_pkg::ST_MISS;
                        state_next  = chit_pkg::S_FINISH;
                    end
                end
            end

            // bucket = key mod BUCKETS by reciprocal multiplication
            chit_pkg::S_MUL_LO:
            begin
                prod_next  = {16'd0, mul_part};
                state_next = chit_pkg::S_MUL_HI;
            end

            chit_pkg::S_MUL_HI:
            begin
                prod_next  = prod_reg + {mul_part, 16'd0};
                state_next = chit_pkg::S_REM;
            end

            chit_pkg::S_REM:
            begin
                rem_next   = rem_full[BW-1:0];
                state_next = chit_pkg::S_HEAD_RD;
            end

            chit_pkg::S_HEAD_RD:
            begin
                state_next = chit_pkg::S_HEAD_WAIT;
            end

            chit_pkg::S_HEAD_WAIT:
            begin
                if (act_reg == chit_pkg::ACT_INSERT)
                begin
                    // link the popped slot in at the chain head
                    ent_we        = 1'b1;
                    link_we       = 1'b1;
                    link_waddr    = stack_q;
                    link_wdata    = head_q;
                    head_we       = 1'b1;
                    head_wdata    = LW'(stack_q);
                    free_cnt_next = free_cnt_reg - LW'(1);
                    state_next    = chit_pkg::S_FINISH;
                end
                else
                begin
                    cur_next   = head_q;
                    prev_next  = NULL_LINK;
                    state_next = chit_pkg::S_WALK_RD;
                end
            end

            chit_pkg::S_WALK_RD:
            begin
                if (cur_reg == NULL_LINK)
                begin
                    if (act_reg == chit_pkg::ACT_UNIQUE)
                    begin
                        uid_next = key_reg;
                    end
                    else
                    begin
                        status_next = chit_pkg::ST_MISS;
                    end
                    state_next = chit_pkg::S_FINISH;
                end
                else
                begin
                    state_next = chit_pkg::S_WALK_CHK;
                end
            end

            chit_pkg::S_WALK_CHK:
            begin
                if (act_reg == chit_pkg::ACT_UNIQUE)
                begin
                    if ($signed(key_q) >= $signed(key_reg))
                    begin
                        best_next   = '0;
                        scan_b_next = '0;
                        state_next  = chit_pkg::S_SCAN_HEAD_RD;
                    end
                    else
                    begin
                        prev_next  = cur_reg;
                        cur_next   = link_q;
                        state_next = chit_pkg::S_WALK_RD;
                    end
                end
                else if (key_q == key_reg)
                begin
                    if (act_reg == chit_pkg::ACT_FIND)
                    begin
                        found_next = hnd_q;
                    end
                    else
                    begin
                        // unlink and push the slot back on the free stack
                        if (prev_reg == NULL_LINK)
                        begin
                            head_we = 1'b1;
                        end
                        else
                        begin
                            link_we = 1'b1;
                        end
                        stack_we      = 1'b1;
                        free_cnt_next = free_cnt_reg + LW'(1);
                    end
                    state_next = chit_pkg::S_FINISH;
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = link_q;
                    state_next = chit_pkg::S_WALK_RD;
                end
            end

            // highest id over every chain, starting from zero
            chit_pkg::S_SCAN_HEAD_RD:
            begin
                head_raddr = scan_b_reg;
                state_next = chit_pkg::S_SCAN_HEAD_WAIT;
            end

            chit_pkg::S_SCAN_HEAD_WAIT:
            begin
                cur_next   = head_q;
                state_next = chit_pkg::S_SCAN_RD;
            end

            chit_pkg::S_SCAN_RD:
            begin
                if (cur_reg == NULL_LINK)
                begin
                    if (scan_b_reg == BW'(BUCKETS - 1))
                    begin
                        uid_next   = best_reg + 32'sd1;
                        state_next = chit_pkg::S_FINISH;
                    end
                    else
                    begin
                        scan_b_next = scan_b_reg + BW'(1);
                        state_next  = chit_pkg::S_SCAN_HEAD_RD;
                    end
                end
                else
                begin
                    state_next = chit_pkg::S_SCAN_CHK;
                end
            end

            chit_pkg::S_SCAN_CHK:
            begin
                if ($signed(key_q) > best_reg)
                begin
                    best_next = key_q;
                end
                cur_next   = link_q;
                state_next = chit_pkg::S_SCAN_RD;
            end

            // hand the result to the output register once it is free
            chit_pkg::S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next.status       = status_reg;
                    out_data_next.found_handle = found_reg;
                    out_data_next.unique_id    = uid_reg;
                    out_valid_next             = 1'b1;
                    state_next                 = chit_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = chit_pkg::S_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == chit_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // checks
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_cnt_reg <= NULL_LINK)
        else $error("free count above capacity");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction taken while busy");

    a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == chit_pkg::S_CLEAR |-> !in_ready)
        else $error("transaction taken during clearing pass");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == chit_pkg::S_FINISH))
        else $error("result raised outside finish");

endmodule

[sim/chit_checker.sv]
// chit_checker: watches both channels of the chained hash id table
// keeps its own copy of the table, predicts each response and compares it
// depends on chit_pkg
module chit_checker #(
    parameter int BUCKETS  = 101,
    parameter int CAPACITY = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_ready,
    input  chit_pkg::req_t  in_data,
    input  logic            out_valid,
    input  logic            out_ready,
    input  chit_pkg::rsp_t  out_data,
    output int              errors,
    output int              pending
);

    localparam int NIL = CAPACITY;

    int             head_of [BUCKETS];
    int             link_of [CAPACITY];
    logic [31:0]    key_of  [CAPACITY];
    logic [31:0]    hnd_of  [CAPACITY];
    int             free_slots [CAPACITY];
    int             free_num;
    chit_pkg::rsp_t due_rsp [$];

    function automatic int bucket_of(logic [31:0] k);
        return int'(k % BUCKETS);
    endfunction

    // newest matching entry, with its predecessor
    function automatic int find_entry(logic [31:0] k, output int prv);
        int cur;
        int n;
        cur = head_of[bucket_of(k)];
        prv = NIL;
        n = 0;
        while (cur < CAPACITY && n < CAPACITY)
        begin
            if (key_of[cur] == k)
                return cur;
            prv = cur;
            cur = link_of[cur];
            n++;
        end
        return NIL;
    endfunction

    function automatic logic signed [31:0] top_id();
        logic signed [31:0] best;
        int cur;
        best = 0;
        for (int b = 0; b < BUCKETS; b++)
        begin
            cur = head_of[b];
            while (cur < CAPACITY)
            begin
                if ($signed(key_of[cur]) > best)
                    best = $signed(key_of[cur]);
                cur = link_of[cur];
            end
        end
        return best;
    endfunction

    function automatic chit_pkg::rsp_t apply_request(chit_pkg::req_t rq);
        chit_pkg::rsp_t r;
        int slot;
        int hit;
        int prv;
        int cur;
        int b;
        logic clash;
        r = '0;
        r.status = chit_pkg::ST_OK;
        case (rq.action)
            chit_pkg::ACT_INSERT:
            begin
                if (free_num == 0)
                    r.status = chit_pkg::ST_FULL;
                else
                begin
                    free_num--;
                    slot = free_slots[free_num];
                    b = bucket_of(rq.key_id);
                    key_of[slot] = rq.key_id;
                    hnd_of[slot] = rq.handle;
                    link_of[slot] = head_of[b];
                    head_of[b] = slot;
                end
            end
            chit_pkg::ACT_REMOVE:
            begin
                hit = find_entry(rq.key_id, prv);
                if (hit >= CAPACITY)
                    r.status = chit_pkg::ST_MISS;
                else
                begin
                    if (prv < CAPACITY)
                        link_of[prv] = link_of[hit];
                    else
                        head_of[bucket_of(rq.key_id)] = link_of[hit];
                    free_slots[free_num] = hit;
                    free_num++;
                end
            end
            chit_pkg::ACT_FIND:
            begin
                hit = (rq.key_id == chit_pkg::KEY_NONE) ? NIL : find_entry(rq.key_id, prv);
                if (hit >= CAPACITY)
                    r.status = chit_pkg::ST_MISS;
                else
                    r.found_handle = hnd_of[hit];
            end
            default:
            begin
                clash = 1'b0;
                cur = head_of[bucket_of(rq.key_id)];
                while (cur < CAPACITY && !clash)
                begin
                    if ($signed(key_of[cur]) >= rq.key_id)
                        clash = 1'b1;
                    cur = link_of[cur];
                end
                r.unique_id = clash ? top_id() + 32'sd1 : rq.key_id;
            end
        endcase
        return r;
    endfunction

    // predict on accepted requests, compare on accepted responses
    always @(posedge clk or negedge rst_n)
    begin
        chit_pkg::rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < BUCKETS; i++)
                head_of[i] = NIL;
            for (int i = 0; i < CAPACITY; i++)
            begin
                free_slots[i] = i;
                link_of[i] = 0;
                key_of[i] = '0;
                hnd_of[i] = '0;
            end
            free_num = CAPACITY;
            errors = 0;
            due_rsp.delete();
            pending = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                due_rsp.push_back(apply_request(in_data));
            if (out_valid && out_ready)
            begin
                if (due_rsp.size() == 0)
                begin
                    $display("%0t: unexpected response %p", $time, out_data);
                    errors++;
                end
                else
                begin
                    want = due_rsp.pop_front();
                    if (want.status != out_data.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, out_data.status);
                        errors++;
                    end
                    if (want.found_handle != out_data.found_handle)
                    begin
                        $display("%0t: found_handle expected %h actual %h", $time,
                                 want.found_handle, out_data.found_handle);
                        errors++;
                    end
                    if (want.unique_id != out_data.unique_id)
                    begin
                        $display("%0t: unique_id expected %0d actual %0d", $time,
                                 want.unique_id, out_data.unique_id);
                        errors++;
                    end
                end
            end
            pending = due_rsp.size();
        end
    end

endmodule

[sim/tb.sv]
// tb: stimulus and verdict for the chained hash id table
// depends on chit_pkg, chained_hash_id_table and chit_checker
module tb;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    chit_pkg::req_t in_data;
    logic           out_valid;
    logic           out_ready;
    chit_pkg::rsp_t out_data;
    int             errors;
    int             pending;
    int             quiet;
    int             hold_req;
    logic           calm;

    localparam int LIMIT = 40000;

    chained_hash_id_table DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    chit_checker CHK (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ids kept few so that chains, duplicates and removals meet often
    logic signed [31:0] recent_ids [16];

    function automatic logic signed [31:0] pick_id();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return 32'sh7FFF_FFFF;
            2:       return -32'sd1;
            3:       return 32'sh8000_0000;
            4, 5:    return $urandom_range(0, 4) * 101 + $urandom_range(0, 2);
            default: return recent_ids[$urandom_range(0, 15)];
        endcase
    endfunction

    // one transaction on the request channel; valid stays up between back-to-back sends
    task automatic send(chit_pkg::action_t act, logic signed [31:0] k, logic [31:0] h);
        int gap;
        logic took;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{action: act, key_id: k, handle: h};
        took = 1'b0;
        while (!took)
        begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // response side: random stall bursts, one long hold-off on request
    initial
    begin
        int hold_done;
        int sink_pause;
        hold_done = 0;
        sink_pause = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_done)
            begin
                hold_done = hold_done + 1;
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            else if (!calm && sink_pause == 0 && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                sink_pause = $urandom_range(1, 13);
            end
            else if (sink_pause > 0)
                sink_pause--;
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int a;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        hold_req = 0;
        calm = 1'b0;
        for (int i = 0; i < 16; i++)
            recent_ids[i] = $urandom_range(0, 600) - 100;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every action, minus one, misses, overflow
        send(chit_pkg::ACT_FIND, 32'sd5, '0);
        send(chit_pkg::ACT_REMOVE, -32'sd1, '0);
        send(chit_pkg::ACT_UNIQUE, 32'sh8000_0000, '0);
        send(chit_pkg::ACT_INSERT, -32'sd1, 32'hFFFF_FFFF);
        send(chit_pkg::ACT_FIND, -32'sd1, '0);
        send(chit_pkg::ACT_REMOVE, -32'sd1, '0);
        send(chit_pkg::ACT_INSERT, 32'sd0, 32'h0);
        send(chit_pkg::ACT_INSERT, 32'sd101, 32'h1111_1111);
        send(chit_pkg::ACT_INSERT, 32'sd101, 32'h2222_2222);
        send(chit_pkg::ACT_FIND, 32'sd101, '0);
        send(chit_pkg::ACT_UNIQUE, 32'sd0, '0);
        send(chit_pkg::ACT_UNIQUE, 32'sd202, '0);
        send(chit_pkg::ACT_REMOVE, 32'sd101, '0);
        send(chit_pkg::ACT_FIND, 32'sd101, '0);
        send(chit_pkg::ACT_INSERT, 32'sh7FFF_FFFF, 32'hA5A5_5A5A);
        send(chit_pkg::ACT_UNIQUE, 32'sh7FFF_FFFF, '0);
        send(chit_pkg::ACT_INSERT, 32'sh8000_0000, 32'h8000_0001);
        send(chit_pkg::ACT_FIND, 32'sh8000_0000, '0);
        send(chit_pkg::ACT_REMOVE, 32'sh7FFF_FFFF, '0);
        wait_drained();

        // fill the pool past capacity while the response side holds off
        hold_req = hold_req + 1;
        for (int i = 0; i < 262; i++)
            send(chit_pkg::ACT_INSERT, $urandom_range(0, 1000), $urandom);
        send(chit_pkg::ACT_UNIQUE, 32'sd3, '0);
        wait_drained();
        for (int i = 0; i < 80; i++)
            send(chit_pkg::ACT_REMOVE, $urandom_range(0, 1000), '0);
        for (int i = 0; i < 256; i++)
            send(chit_pkg::ACT_REMOVE, $urandom_range(0, 1000), '0);
        wait_drained();

        // random mix, last part without idling
        for (int i = 0; i < 432; i++)
        begin
            if (i == 360)
                calm = 1'b1;
            a = $urandom_range(0, 9);
            if (a < 4)
                send(chit_pkg::ACT_INSERT, pick_id(), $urandom);
            else if (a < 6)
                send(chit_pkg::ACT_REMOVE, pick_id(), $urandom);
            else if (a < 8)
                send(chit_pkg::ACT_FIND, pick_id(), $urandom);
            else
                send(chit_pkg::ACT_UNIQUE, pick_id(), $urandom);
            if ($urandom_range(0, 7) == 0)
                recent_ids[$urandom_range(0, 15)] = $urandom;
        end

        wait_drained();
        repeat (2000) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[files.f]
hdl/chit_pkg.sv
hdl/chained_hash_id_table.sv
sim/chit_checker.sv
sim/tb.sv
